// File: rtl/dmpwc_pkg.sv
// Shared types, constants and repeat-unit table for the window counter.
package dmpwc_pkg;

  localparam int PATTERN_LEN_DEF  = 60;
  localparam int NUM_PATTERNS_DEF = 14;
  localparam int NUM_SETS_DEF     = 3;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Fixed field widths of the words on the ports
  localparam int HIT_W  = 32;
  localparam int UNIT_FW = 4;
  localparam int SET_FW  = 2;

  localparam int UNIT_TBL_N   = 14;
  localparam int UNIT_TBL_LEN = 60;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [1:0]         base;
    logic               read_end;
    logic [SET_FW-1:0]  read_set;
    logic [UNIT_FW-1:0] unit_index;
  } in_word_t;

  typedef struct packed {
    logic [UNIT_FW-1:0] unit_echo;
    logic [SET_FW-1:0]  set_echo;
    logic [HIT_W-1:0]   hit_count;
  } out_word_t;

  // Repeat units, first character in the top byte
  localparam logic [8*UNIT_TBL_LEN-1:0] UNIT_TEXT [UNIT_TBL_N] = '{
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCCCCCCCA",
    "GCCCACGGTGTCACCTCGGCCCCGGAGAGCAGGCCGGCCCCGGGCTCCACCGCGCCCGCA",
    "GCCCACGGTGTCACCTCGGCCCCGGAGAGCAGGCCGGCCCCGGGCTCCACCGCCCCCCCA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCCCCCCAA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCCGCCCCGGGCTCCACCGCCCCCCCA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCCGCCCCGGGCTCCACCGCGCCCGCA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCCCCCACA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCGCCCGCA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCACCCCCA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCCCCCCCG",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCCGCCCCA",
    "GCCCACGGTGTCACCTCGGCCCCGGACACCAGGCCGGCCCCGGGCTCCACCGCGCCCCCA",
    "GCCCACGGTGTCACCTCGGCACCGGAGAGCAGGCCGGCCCCGGGCTCCACCGCGCCCGCA",
    "GCCCACGGTGTCACCTCGGCCCCGGAGAGCAGGCCGGCCCTGGGCTCCACCGCCCCCCCA"
  };

  // Base code of unit u at position i; outside the table the unit reads as A
  function automatic logic [1:0] unit_base(input int u, input int i);
    logic [7:0] c;
    if (u >= UNIT_TBL_N || i >= UNIT_TBL_LEN) begin
      return BASE_A;
    end
    c = UNIT_TEXT[u][8*(UNIT_TBL_LEN-1-i) +: 8];
    case (c)
      "C": return BASE_C;
      "G": return BASE_G;
      "T": return BASE_T;
      default: return BASE_A;
    endcase
  endfunction

endpackage

// File: rtl/dmpwc_matcher.sv
// Parallel forward and reverse-complement compare of the window against all units.
module dmpwc_matcher #(
  parameter int PATTERN_LEN  = dmpwc_pkg::PATTERN_LEN_DEF,
  parameter int NUM_PATTERNS = dmpwc_pkg::NUM_PATTERNS_DEF
) (
  input  logic [PATTERN_LEN-1:0][1:0]  window,  // entry 0 oldest
  output logic [NUM_PATTERNS-1:0][1:0] hits     // 0, 1 or 2 per unit
);

  always_comb begin
    logic fwd;
    logic rev;
    for (int u = 0; u < NUM_PATTERNS; u++) begin
      fwd = 1'b1;
      rev = 1'b1;
      for (int i = 0; i < PATTERN_LEN; i++) begin
        if (window[i] != dmpwc_pkg::unit_base(u, i)) fwd = 1'b0;
        // complement of code b is 3 - b, i.e. bitwise inverse
        if (~window[PATTERN_LEN-1-i] != dmpwc_pkg::unit_base(u, i)) rev = 1'b0;
      end
      hits[u] = {fwd & rev, fwd ^ rev};
    end
  end

endmodule

// File: rtl/dna_multi_pattern_window_counter_core.sv
// A read word's result shows on out_* from the output register, after stages 1 and 2.
// Throughput: one word per cycle; in_ready drops only while a read sits in the
//   last stage and the previous result is still waiting on the output register.
// Reset (rst_n low, synchronous): empties the window, clears the pipeline and
//   marks every counter row invalid so it reads as zero; no clearing pass.
module dna_multi_pattern_window_counter_core #(
  parameter int PATTERN_LEN  = dmpwc_pkg::PATTERN_LEN_DEF,
  parameter int NUM_PATTERNS = dmpwc_pkg::NUM_PATTERNS_DEF,
  parameter int NUM_SETS     = dmpwc_pkg::NUM_SETS_DEF,
  parameter int COUNT_WIDTH  = dmpwc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmpwc_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dmpwc_pkg::out_word_t out_word
);

  // Pipeline:
  //   accept edge : base shifts into the window, word goes to stage 1
  //   stage 1     : window holds this word's view; matcher runs, counter row read
  //   stage 2     : row (memory or forwarded) + increments, saturate, write back;
  //                 read words pick their counter into the output register
  // The counters sit in one memory, one row per read set holding all units, so
  // a push costs a single read-modify-write whatever the number of hits.

  localparam int FILL_W = $clog2(PATTERN_LEN + 1);
  localparam int ROW_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int UNIT_W = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [NUM_PATTERNS-1:0][COUNT_WIDTH-1:0] row_t;
  typedef logic [NUM_PATTERNS-1:0][1:0]             inc_t;

  typedef struct packed {
    logic                          valid;
    dmpwc_pkg::cmd_t               command;
    logic                          full;     // window full after this base
    logic                          set_ok;
    logic                          unit_ok;
    logic [dmpwc_pkg::SET_FW-1:0]  read_set;
    logic [dmpwc_pkg::UNIT_FW-1:0] unit_index;
  } stage_t;

  // ---------------------------------------------------------------- flow
  logic adv;     // whole pipeline moves this cycle
  logic take;    // input word accepted
  logic s2_read;
  logic s2_write;
  stage_t s1_r, s1_nxt, s2_r;

  assign s2_read  = s2_r.valid && (s2_r.command == dmpwc_pkg::CMD_READ);
  assign s2_write = s2_r.valid && (s2_r.command == dmpwc_pkg::CMD_PUSH) &&
                    s2_r.full && s2_r.set_ok;

  logic out_valid_r;
  dmpwc_pkg::out_word_t out_word_r;

  // only a read in stage 2 needs the output register
  assign adv      = !(s2_read && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign take     = in_valid && adv;

  // ---------------------------------------------------------------- window
  logic [PATTERN_LEN-1:0][1:0] win_r;
  logic [FILL_W-1:0] fill_r, fill_nxt, fill_inc;
  logic              push_take;
  logic              full_now;

  assign push_take = take && (in_word.command == dmpwc_pkg::CMD_PUSH);

  always_comb begin
    fill_inc = (fill_r < FILL_W'(PATTERN_LEN)) ? fill_r + FILL_W'(1) : fill_r;
    full_now = (fill_inc == FILL_W'(PATTERN_LEN));
    fill_nxt = fill_r;
    if (push_take) begin
      fill_nxt = in_word.read_end ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // newest base enters at the top; hits count only when the window is full
  always_ff @(posedge clk) begin
    if (push_take) begin
      win_r <= {in_word.base, win_r[PATTERN_LEN-1:1]};
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_comb begin
    s1_nxt.valid      = take;
    s1_nxt.command    = in_word.command;
    s1_nxt.full       = full_now;
    s1_nxt.set_ok     = (in_word.read_set < NUM_SETS);
    s1_nxt.unit_ok    = (in_word.unit_index < NUM_PATTERNS);
    s1_nxt.read_set   = in_word.read_set;
    s1_nxt.unit_index = in_word.unit_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  inc_t hits;

  dmpwc_matcher #(
    .PATTERN_LEN  (PATTERN_LEN),
    .NUM_PATTERNS (NUM_PATTERNS)
  ) u_matcher (
    .window (win_r),
    .hits   (hits)
  );

  // ---------------------------------------------------------------- counters
  row_t             cnt_mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_valid_r;
  row_t             rd_row_q;
  logic             rd_vld_q;
  logic [ROW_W-1:0] s1_row, s2_row;
  logic [ROW_W+dmpwc_pkg::SET_FW-1:0] s1_set_ext, s2_set_ext;

  assign s1_set_ext = {{ROW_W{1'b0}}, s1_r.read_set};
  assign s2_set_ext = {{ROW_W{1'b0}}, s2_r.read_set};
  assign s1_row     = s1_set_ext[ROW_W-1:0];
  assign s2_row     = s2_set_ext[ROW_W-1:0];

  row_t upd_row;
  inc_t inc_r;

  always_ff @(posedge clk) begin
    if (adv && s2_write) begin
      cnt_mem[s2_row] <= upd_row;
    end
    if (adv && s1_r.valid && s1_r.set_ok) begin
      rd_row_q <= cnt_mem[s1_row];
      rd_vld_q <= row_valid_r[s1_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (adv && s2_write) begin
      row_valid_r[s2_row] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (adv) begin
      s2_r <= s1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      inc_r <= hits;
    end
  end

  // last write back, forwarded when it hit the row read in the same cycle
  logic             wb_valid_r;
  logic [ROW_W-1:0] wb_row_r;
  row_t             wb_data_r;
  row_t             cur_row;

  always_comb begin
    if (wb_valid_r && (wb_row_r == s2_row)) begin
      cur_row = wb_data_r;
    end else if (rd_vld_q) begin
      cur_row = rd_row_q;
    end else begin
      cur_row = '0;
    end
  end

  always_comb begin
    logic [COUNT_WIDTH:0] sum;
    for (int u = 0; u < NUM_PATTERNS; u++) begin
      sum = {1'b0, cur_row[u]} + (COUNT_WIDTH+1)'(inc_r[u]);
      upd_row[u] = sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r <= 1'b0;
    end else if (adv) begin
      wb_valid_r <= s2_write;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_write) begin
      wb_row_r  <= s2_row;
      wb_data_r <= upd_row;
    end
  end

  // ---------------------------------------------------------------- result
  logic [UNIT_W+dmpwc_pkg::UNIT_FW-1:0] unit_ext;
  logic [UNIT_W-1:0]                    unit_sel;
  logic [COUNT_WIDTH-1:0]               cnt_sel;
  logic [dmpwc_pkg::HIT_W+COUNT_WIDTH-1:0] cnt_ext;

  assign unit_ext = {{UNIT_W{1'b0}}, s2_r.unit_index};
  assign unit_sel = unit_ext[UNIT_W-1:0];
  assign cnt_sel  = (s2_r.set_ok && s2_r.unit_ok) ? cur_row[unit_sel] : '0;
  assign cnt_ext  = {{dmpwc_pkg::HIT_W{1'b0}}, cnt_sel};

  // a new read loads while the old word drains, otherwise the word holds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (adv && s2_read) || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_read) begin
      out_word_r.unit_echo <= s2_r.unit_index;
      out_word_r.set_echo  <= s2_r.read_set;
      out_word_r.hit_count <= cnt_ext[dmpwc_pkg::HIT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/dmpwc_checker.sv
// Port-level checks for the window counter core, bound to the top level.
module dmpwc_core_sva #(
  parameter int NUM_PATTERNS = dmpwc_pkg::NUM_PATTERNS_DEF,
  parameter int NUM_SETS     = dmpwc_pkg::NUM_SETS_DEF
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input dmpwc_pkg::in_word_t  in_word,
  input logic                 out_valid,
  input logic                 out_ready,
  input dmpwc_pkg::out_word_t out_word
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // input only stalls behind a waiting result
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a fresh result comes from an earlier accepted read
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |->
      $past(in_valid && in_ready && (in_word.command == dmpwc_pkg::CMD_READ), 3))
    else $error("result without matching read");

  // out-of-range counter reads return zero
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_word.set_echo >= NUM_SETS) ||
                  (out_word.unit_echo >= NUM_PATTERNS)) |->
      (out_word.hit_count == '0))
    else $error("out-of-range read returned nonzero count");

endmodule

bind dna_multi_pattern_window_counter_core dmpwc_core_sva #(
  .NUM_PATTERNS (NUM_PATTERNS),
  .NUM_SETS     (NUM_SETS)
) u_dmpwc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

// File: dv/dmpwc_checker.sv
// Channel monitor and predictor for the DNA multi-pattern window counter.
module dmpwc_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  dmpwc_pkg::in_word_t  in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  dmpwc_pkg::out_word_t out_word,
  input  logic                 end_check,
  output int                   fail_count,
  output int                   outstanding
);

  localparam int WIN_LEN = dmpwc_pkg::PATTERN_LEN_DEF;
  localparam int NUNITS  = dmpwc_pkg::NUM_PATTERNS_DEF;
  localparam int NSETS   = dmpwc_pkg::NUM_SETS_DEF;

  logic [1:0]                  unit_seq [NUNITS][WIN_LEN];
  logic [1:0]                  win [WIN_LEN];
  int                          fill;
  logic [dmpwc_pkg::HIT_W-1:0] set_unit_hits [NSETS][NUNITS];
  dmpwc_pkg::out_word_t        readback_q [$];
  dmpwc_pkg::out_word_t        head;
  bit                          leftover_done;

  function automatic logic [1:0] char_code(input logic [7:0] c);
    case (c)
      "C": return dmpwc_pkg::BASE_C;
      "G": return dmpwc_pkg::BASE_G;
      "T": return dmpwc_pkg::BASE_T;
      default: return dmpwc_pkg::BASE_A;
    endcase
  endfunction

  task automatic clear_model();
    fill = 0;
    for (int s = 0; s < NSETS; s++) begin
      for (int u = 0; u < NUNITS; u++) begin
        set_unit_hits[s][u] = '0;
      end
    end
    readback_q.delete();
  endtask

  task automatic report(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic bump(input int s, input int u);
    if (set_unit_hits[s][u] != '1) begin
      set_unit_hits[s][u] = set_unit_hits[s][u] + 1'b1;
    end
  endtask

  // One accepted word: a read queues its readback, a push slides the window.
  task automatic apply_word(input dmpwc_pkg::in_word_t w);
    dmpwc_pkg::out_word_t rb;
    bit                   fwd;
    bit                   rev;
    if (w.command == dmpwc_pkg::CMD_READ) begin
      rb.unit_echo = w.unit_index;
      rb.set_echo  = w.read_set;
      rb.hit_count = '0;
      if (w.read_set < NSETS && w.unit_index < NUNITS) begin
        rb.hit_count = set_unit_hits[w.read_set][w.unit_index];
      end
      readback_q = {readback_q, rb};
      return;
    end
    if (fill < WIN_LEN) begin
      win[fill] = w.base;
      fill++;
    end else begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win[i] = win[i+1];
      end
      win[WIN_LEN-1] = w.base;
    end
    if (fill == WIN_LEN && w.read_set < NSETS) begin
      for (int u = 0; u < NUNITS; u++) begin
        fwd = 1'b1;
        rev = 1'b1;
        for (int i = 0; i < WIN_LEN; i++) begin
          if (win[i] != unit_seq[u][i]) fwd = 1'b0;
          if (~win[WIN_LEN-1-i] != unit_seq[u][i]) rev = 1'b0;
        end
        if (fwd) bump(w.read_set, u);
        if (rev) bump(w.read_set, u);
      end
    end
    if (w.read_end) begin
      fill = 0;
    end
  endtask

  initial begin
    fail_count    = 0;
    outstanding   = 0;
    leftover_done = 1'b0;
    for (int u = 0; u < NUNITS; u++) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        unit_seq[u][i] = dmpwc_pkg::BASE_A;
        if (u < dmpwc_pkg::UNIT_TBL_N && i < dmpwc_pkg::UNIT_TBL_LEN) begin
          unit_seq[u][i] = char_code(
            dmpwc_pkg::UNIT_TEXT[u][8*(dmpwc_pkg::UNIT_TBL_LEN-1-i) +: 8]);
        end
      end
    end
    clear_model();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (out_valid && out_ready) begin
        if (readback_q.size() == 0) begin
          report($sformatf("result with no read pending: %p", out_word));
        end else begin
          head = readback_q.pop_front();
          if (out_word.unit_echo != head.unit_echo) begin
            report($sformatf("unit_echo %0d, want %0d",
                             out_word.unit_echo, head.unit_echo));
          end
          if (out_word.set_echo != head.set_echo) begin
            report($sformatf("set_echo %0d, want %0d",
                             out_word.set_echo, head.set_echo));
          end
          if (out_word.hit_count !== head.hit_count) begin
            report($sformatf("hit_count %0d, want %0d (set %0d unit %0d)",
                             out_word.hit_count, head.hit_count,
                             head.set_echo, head.unit_echo));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_word(in_word);
      end
      if (end_check && !leftover_done) begin
        leftover_done = 1'b1;
        if (readback_q.size() != 0) begin
          report($sformatf("%0d expected readbacks never arrived", readback_q.size()));
        end
      end
    end
    outstanding = readback_q.size();
  end

endmodule

// File: dv/tb_dna_multi_pattern_window_counter_core.sv
// Testbench top for the DNA window counter: stimulus, output pacing and verdict.
module tb_dna_multi_pattern_window_counter_core;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int STALL_CYCLES = 400;
  localparam int RANDOM_WORDS = 700;
  localparam int WIN_LEN      = dmpwc_pkg::PATTERN_LEN_DEF;
  localparam int NUNITS       = dmpwc_pkg::NUM_PATTERNS_DEF;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  dmpwc_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_ready;
  dmpwc_pkg::out_word_t out_word;
  logic                 end_check;

  int fail_count;
  int outstanding;
  int cycle_count;

  // Handshake between stimulus and the output pacer for the long hold-off
  int stall_requests;
  int stalls_served;
  bit no_gaps;

  int words_sent;
  int bases_sent;
  int reads_sent;
  int units_planted;
  bit stall_done;
  bit pause_done;

  // Repeat units as base codes, used to plant hits in reads
  logic [1:0] unit_seq [NUNITS][WIN_LEN];

  dna_multi_pattern_window_counter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  dmpwc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .end_check   (end_check),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [1:0] char_code(input logic [7:0] c);
    case (c)
      "C": return dmpwc_pkg::BASE_C;
      "G": return dmpwc_pkg::BASE_G;
      "T": return dmpwc_pkg::BASE_T;
      default: return dmpwc_pkg::BASE_A;
    endcase
  endfunction

  function automatic logic [1:0] rand_base();
    return 2'($urandom_range(0, 3));
  endfunction

  // Output pacer. Each result may wait with out_ready low, but never while
  // no_gaps is set. A pending hold-off request keeps out_ready low for
  // STALL_CYCLES so the pipeline backs up into in_ready.
  initial begin
    int n;
    out_ready     = 1'b0;
    stalls_served = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    @(negedge clk);
    forever begin
      if (stall_requests != stalls_served) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(negedge clk);
        stalls_served++;
      end else begin
        n = no_gaps ? 0 : $urandom_range(0, 10);
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Offer one word after a random gap; returns at the falling edge after
  // it was taken. valid stays high across back-to-back words.
  task automatic send_word(input dmpwc_pkg::in_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    if (w.command == dmpwc_pkg::CMD_READ) reads_sent++;
    else bases_sent++;
    @(negedge clk);
  endtask

  // unit_index is a don't-care on a push, so it gets random bits
  task automatic push_base(input logic [1:0] b, input int set, input bit last);
    dmpwc_pkg::in_word_t w;
    w.command    = dmpwc_pkg::CMD_PUSH;
    w.base       = b;
    w.read_end   = last;
    w.read_set   = 2'(set);
    w.unit_index = 4'($urandom_range(0, 15));
    send_word(w);
  endtask

  // base and read_end are ignored by a read, so they get random bits too
  task automatic read_counter(input int set, input int unit);
    dmpwc_pkg::in_word_t w;
    w.command    = dmpwc_pkg::CMD_READ;
    w.base       = rand_base();
    w.read_end   = 1'($urandom_range(0, 1));
    w.read_set   = 2'(set);
    w.unit_index = 4'(unit);
    send_word(w);
  endtask

  task automatic read_random();
    read_counter($urandom_range(0, 3), $urandom_range(0, 15));
  endtask

  // A read that carries one or two copies of a repeat unit, forward or as a
  // reverse complement, inside random flanks; sometimes with one base hit by
  // a random substitution, stray set tags, counter reads mixed in, or left
  // open so the next read keeps sliding the same window.
  task automatic plant_repeat();
    logic [1:0] seq [$];
    int s;
    int u;
    int strand;
    int copies;
    bit keep_open;
    s         = ($urandom_range(0, 5) == 0) ? 3 : $urandom_range(0, 2);
    u         = $urandom_range(0, NUNITS - 1);
    strand    = $urandom_range(0, 1);
    copies    = ($urandom_range(0, 3) == 0) ? 2 : 1;
    keep_open = ($urandom_range(0, 7) == 0);
    repeat ($urandom_range(0, 6)) seq = {seq, rand_base()};
    for (int k = 0; k < copies; k++) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        seq = {seq, (strand ? ~unit_seq[u][WIN_LEN-1-i] : unit_seq[u][i])};
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      seq[$urandom_range(0, seq.size() - 1)] = rand_base();
    end
    repeat ($urandom_range(0, 6)) seq = {seq, rand_base()};
    for (int i = 0; i < seq.size(); i++) begin
      if ($urandom_range(0, 24) == 0) read_random();
      push_base(seq[i], ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : s,
                (i == seq.size() - 1) && !keep_open);
    end
    units_planted++;
  endtask

  // Random bases; long ones get full-window compares that almost never hit
  task automatic noise_read();
    int len;
    len = $urandom_range(1, 70);
    for (int i = 0; i < len; i++) begin
      push_base(rand_base(), $urandom_range(0, 3), i == len - 1);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  initial begin
    int pick;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_word        = '0;
    end_check      = 1'b0;
    stall_requests = 0;
    no_gaps        = 1'b0;
    words_sent     = 0;
    bases_sent     = 0;
    reads_sent     = 0;
    units_planted  = 0;
    stall_done     = 1'b0;
    pause_done     = 1'b0;
    for (int u = 0; u < NUNITS; u++) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        unit_seq[u][i] = char_code(
          dmpwc_pkg::UNIT_TEXT[u][8*(dmpwc_pkg::UNIT_TBL_LEN-1-i) +: 8]);
      end
    end

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reads at the field extremes, out-of-range set and unit,
    // reads shorter than a window, pushes tagged with an invalid set.
    read_counter(0, 0);
    read_counter(2, NUNITS - 1);
    read_counter(3, NUNITS - 1);
    read_counter(0, NUNITS);
    read_counter(3, 15);
    read_counter(1, 7);
    push_base(dmpwc_pkg::BASE_A, 0, 1'b0);
    push_base(dmpwc_pkg::BASE_C, 0, 1'b0);
    push_base(dmpwc_pkg::BASE_G, 0, 1'b0);
    push_base(dmpwc_pkg::BASE_T, 0, 1'b0);
    push_base(dmpwc_pkg::BASE_A, 0, 1'b1);
    push_base(dmpwc_pkg::BASE_T, 3, 1'b0);
    push_base(dmpwc_pkg::BASE_T, 3, 1'b0);
    push_base(dmpwc_pkg::BASE_T, 3, 1'b0);
    push_base(dmpwc_pkg::BASE_T, 3, 1'b1);
    push_base(dmpwc_pkg::BASE_G, 2, 1'b1);
    read_counter(0, 0);
    read_counter(1, 5);
    wait_drained();

    // Random: half reads with planted repeat units, the rest noise reads and
    // bursts of counter reads
    while (words_sent < RANDOM_WORDS) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 5) begin
        plant_repeat();
      end else if (pick < 7) begin
        noise_read();
      end else begin
        repeat ($urandom_range(1, 6)) read_random();
      end

      // Output held off while reads keep coming back to back
      if (!stall_done && words_sent > 400) begin
        stall_done = 1'b1;
        stall_requests++;
        no_gaps = 1'b1;
        repeat (24) read_random();
        no_gaps = 1'b0;
      end

      // Sender goes quiet until every readback is in
      if (!pause_done && words_sent > 600) begin
        pause_done = 1'b1;
        wait_drained();
      end
    end

    // Closing sweep over every counter, out-of-range ones too
    no_gaps = 1'b0;
    for (int s = 0; s < 4; s++) begin
      for (int u = 0; u < 16; u++) begin
        read_counter(s, u);
      end
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    end_check <= 1'b1;
    @(posedge clk);
    @(negedge clk);

    $display("covered %0d words: %0d bases, %0d counter reads, %0d planted repeat units",
             words_sent, bases_sent, reads_sent, units_planted);
    $display("with one %0d-cycle output hold-off; %0d mismatches", STALL_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
